// ----- rtl/sgs_pkg.sv -----
// ----------------------------------------------------------------------------
// sgs_pkg
// Shared types, constants and window tables of the Savitzky-Golay smoother.
// ----------------------------------------------------------------------------
package sgs_pkg;

  localparam int SAMPLE_WIDTH        = 24;
  localparam int COEF_FRAC_BITS_DEF  = 15;
  localparam int MAX_TAPS            = 11;
  localparam int NUM_MODES           = 4;
  localparam int QUEUE_DEPTH         = 2;
  localparam int CNT_W               = $clog2(MAX_TAPS + 1);
  localparam int HIST_IDX_W          = $clog2(MAX_TAPS);
  localparam int SPAN_W              = 3;

  typedef enum logic [1:0] {
    MODE_L2R2 = 2'd0,
    MODE_L1R3 = 2'd1,
    MODE_L5R5 = 2'd2,
    MODE_L4R4 = 2'd3
  } mode_t;

  typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;

  typedef struct packed {
    sample_t sample_in;
    logic    frame_end;
  } sgs_in_t;

  typedef struct packed {
    sample_t sample_out;
    logic    last_out;
  } sgs_out_t;

  typedef struct packed {
    sample_t [MAX_TAPS-1:0] hist;
    mode_t                  mode;
    logic                   emit_main;
    logic                   smooth;
    logic [SPAN_W-1:0]      drain;
    logic                   last;
  } sgs_job_t;

  typedef struct packed {
    logic     push;
    sgs_job_t job;
  } sgs_push_t;

  typedef struct packed {
    sample_t [MAX_TAPS-1:0] hist;
    mode_t                  mode;
    logic                   smooth;
    sample_t                raw;
    logic                   last;
  } sgs_op_t;

  // Weights in thousandths, indexed by history position (newest first).
  localparam int TAP_MILLI [NUM_MODES][MAX_TAPS] = '{
    '{ -86,  343,  486, 343, -86,   0,   0,    0,   0,  0,   0},
    '{-143,  171,  343, 372, 257,   0,   0,    0,   0,  0,   0},
    '{ -84,   21,  103, 161, 196, 206, 196,  161, 103, 21, -84},
    '{  35, -128,   70, 315, 416, 315,  70, -128,  35,  0,   0}
  };

  function automatic longint coef_fixed(input int milli, input int frac);
    longint a;
    longint q;
    a = (milli < 0) ? -longint'(milli) : longint'(milli);
    q = ((a <<< frac) + 64'sd500) / 64'sd1000;
    return (milli < 0) ? -q : q;
  endfunction

  function automatic logic [SPAN_W-1:0] span_left(input mode_t m);
    logic [SPAN_W-1:0] s;
    unique case (m)
      MODE_L2R2: s = SPAN_W'(2);
      MODE_L1R3: s = SPAN_W'(1);
      MODE_L5R5: s = SPAN_W'(5);
      MODE_L4R4: s = SPAN_W'(4);
      default:   s = SPAN_W'(5);
    endcase
    return s;
  endfunction

  function automatic logic [SPAN_W-1:0] span_right(input mode_t m);
    logic [SPAN_W-1:0] s;
    unique case (m)
      MODE_L2R2: s = SPAN_W'(2);
      MODE_L1R3: s = SPAN_W'(3);
      MODE_L5R5: s = SPAN_W'(5);
      MODE_L4R4: s = SPAN_W'(4);
      default:   s = SPAN_W'(5);
    endcase
    return s;
  endfunction

endpackage

// ----- rtl/sgs_front.sv -----
// ----------------------------------------------------------------------------
// sgs_front
// Sample history, frame count and mode register; classifies each word.
// ----------------------------------------------------------------------------
module sgs_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              sample_valid,
  output logic              sample_ready,
  input  sgs_pkg::sgs_in_t  sample_word,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_wdata,
  input  logic              queue_full,
  output sgs_pkg::sgs_push_t push_req
);
  import sgs_pkg::*;

  mode_t                  mode;
  sample_t [MAX_TAPS-1:0] hist;
  logic [CNT_W-1:0]       count;

  sample_t [MAX_TAPS-1:0] hist_next;
  logic [CNT_W-1:0]       cnt_inc;
  logic [SPAN_W-1:0]      nl;
  logic [SPAN_W-1:0]      nr;
  logic                   accept;
  logic                   emit_main;

  assign sample_ready = !queue_full;
  assign accept       = sample_valid && sample_ready;
  assign hist_next    = {hist[MAX_TAPS-2:0], sample_word.sample_in};
  assign cnt_inc      = (count == CNT_W'(MAX_TAPS)) ? count : count + CNT_W'(1);
  assign nl           = span_left(mode);
  assign nr           = span_right(mode);
  assign emit_main    = cnt_inc > CNT_W'(nr);

  always_comb begin
    push_req.push          = accept && (emit_main || sample_word.frame_end);
    push_req.job.hist      = hist_next;
    push_req.job.mode      = mode;
    push_req.job.emit_main = emit_main;
    push_req.job.smooth    = cnt_inc > (CNT_W'(nl) + CNT_W'(nr));
    push_req.job.last      = sample_word.frame_end;
    if (!sample_word.frame_end) begin
      push_req.job.drain = '0;
    end else if (cnt_inc < CNT_W'(nr)) begin
      push_req.job.drain = cnt_inc[SPAN_W-1:0];
    end else begin
      push_req.job.drain = nr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode  <= MODE_L5R5;
      count <= '0;
    end else begin
      if (cfg_we) begin
        mode <= mode_t'(cfg_wdata);
      end
      if (accept) begin
        count <= sample_word.frame_end ? '0 : cnt_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hist <= '0;
    end else if (accept) begin
      hist <= hist_next;
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(MAX_TAPS))
    else $error("frame count beyond window depth");

  a_end_drains: assert property (@(posedge clk) disable iff (rst)
    push_req.push && push_req.job.last |-> push_req.job.drain != '0)
    else $error("frame end with nothing to drain");

  a_end_clears: assert property (@(posedge clk) disable iff (rst)
    accept && sample_word.frame_end |=> count == '0)
    else $error("count not cleared after frame end");

endmodule

// ----- rtl/sgs_queue.sv -----
// ----------------------------------------------------------------------------
// sgs_queue
// Short job queue between classification and the output sequencer.
// ----------------------------------------------------------------------------
module sgs_queue (
  input  logic               clk,
  input  logic               rst,
  input  sgs_pkg::sgs_push_t push_req,
  output logic               full,
  input  logic               pop,
  output logic               empty,
  output sgs_pkg::sgs_job_t  head
);
  import sgs_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int OCC_W = $clog2(QUEUE_DEPTH + 1);

  sgs_job_t         entries [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [OCC_W-1:0] occ;

  assign full  = occ == OCC_W'(QUEUE_DEPTH);
  assign empty = occ == '0;
  assign head  = entries[rd_ptr];

  function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      occ    <= '0;
    end else begin
      if (push_req.push) begin
        wr_ptr <= wrap_inc(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= wrap_inc(rd_ptr);
      end
      if (push_req.push && !pop) begin
        occ <= occ + OCC_W'(1);
      end else if (pop && !push_req.push) begin
        occ <= occ - OCC_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push_req.push) begin
      entries[wr_ptr] <= push_req.job;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push_req.push |-> !full)
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> !empty)
    else $error("pop from empty queue");

  a_occ_range: assert property (@(posedge clk) disable iff (rst)
    occ <= OCC_W'(QUEUE_DEPTH))
    else $error("queue occupancy out of range");

endmodule

// ----- rtl/sgs_seq.sv -----
// ----------------------------------------------------------------------------
// sgs_seq
// Walks the head job: the lagged word first, then the raw drain words.
// ----------------------------------------------------------------------------
module sgs_seq (
  input  logic              clk,
  input  logic              rst,
  input  logic              empty,
  input  sgs_pkg::sgs_job_t head,
  output logic              pop,
  input  logic              advance,
  output logic              op_valid,
  output sgs_pkg::sgs_op_t  op
);
  import sgs_pkg::*;

  logic              main_done;
  logic [SPAN_W-1:0] drain_sent;

  logic                  issue;
  logic                  is_main;
  logic                  final_op;
  logic [SPAN_W-1:0]     drain_idx;
  logic [HIST_IDX_W-1:0] raw_idx;

  assign issue     = !empty && advance;
  assign is_main   = head.emit_main && !main_done;
  assign drain_idx = head.drain - SPAN_W'(1) - drain_sent;
  assign raw_idx   = is_main ? HIST_IDX_W'(span_right(head.mode)) : HIST_IDX_W'(drain_idx);
  assign final_op  = is_main ? (head.drain == '0) : (drain_sent == head.drain - SPAN_W'(1));
  assign pop       = issue && final_op;
  assign op_valid  = issue;

  always_comb begin
    op.hist   = head.hist;
    op.mode   = head.mode;
    op.smooth = is_main && head.smooth;
    op.raw    = head.hist[raw_idx];
    op.last   = final_op && head.last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      main_done  <= 1'b0;
      drain_sent <= '0;
    end else if (issue) begin
      if (final_op) begin
        main_done  <= 1'b0;
        drain_sent <= '0;
      end else if (is_main) begin
        main_done <= 1'b1;
      end else begin
        drain_sent <= drain_sent + SPAN_W'(1);
      end
    end
  end

  a_drain_bound: assert property (@(posedge clk) disable iff (rst)
    !empty && !is_main |-> drain_sent < head.drain)
    else $error("drain index past job length");

  a_idle_clean: assert property (@(posedge clk) disable iff (rst)
    empty |-> !main_done && drain_sent == '0)
    else $error("sequencer progress left with no job");

  a_last_pops: assert property (@(posedge clk) disable iff (rst)
    op_valid && op.last |-> pop)
    else $error("frame end word before job finished");

endmodule

// ----- rtl/sgs_mac.sv -----
// ----------------------------------------------------------------------------
// sgs_mac
// Tap multipliers, registered adder tree, rounding, saturation, output word.
// ----------------------------------------------------------------------------
module sgs_mac #(
  parameter int COEF_FRAC_BITS = sgs_pkg::COEF_FRAC_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              op_valid,
  input  sgs_pkg::sgs_op_t  op,
  output logic              advance,
  output logic              result_valid,
  input  logic              result_ready,
  output sgs_pkg::sgs_out_t result_word
);
  import sgs_pkg::*;

  localparam int CW   = COEF_FRAC_BITS + 1;
  localparam int PW   = SAMPLE_WIDTH + CW;
  localparam int AW   = PW + 4;
  localparam int GRP  = 3;
  localparam int NGRP = 4;
  localparam logic signed [AW-1:0] ROUND = AW'(1) <<< (COEF_FRAC_BITS - 1);
  localparam logic signed [AW-1:0] SAT_HI = (AW'(1) <<< (SAMPLE_WIDTH - 1)) - AW'(1);
  localparam logic signed [AW-1:0] SAT_LO = -(AW'(1) <<< (SAMPLE_WIDTH - 1));

  logic signed [CW-1:0] coef_rom [NUM_MODES][MAX_TAPS];
  logic signed [PW-1:0] mul_a [MAX_TAPS];
  logic signed [PW-1:0] mul_b [MAX_TAPS];

  logic                 p_valid, s1_valid, s2_valid, s3_valid;
  logic                 p_smooth, s1_smooth, s2_smooth, s3_smooth;
  logic                 p_last, s1_last, s2_last, s3_last;
  sample_t              p_raw, s1_raw, s2_raw, s3_raw;
  logic signed [PW-1:0] prod [MAX_TAPS];
  logic signed [AW-1:0] s1_sum [NGRP];
  logic signed [AW-1:0] s2_sum [2];
  logic signed [AW-1:0] s3_total;

  logic signed [AW-1:0] grp_sum [NGRP];
  logic signed [AW-1:0] shifted;
  sample_t              sat_val;

  for (genvar gm = 0; gm < NUM_MODES; gm++) begin : g_mode
    for (genvar gj = 0; gj < MAX_TAPS; gj++) begin : g_tap
      assign coef_rom[gm][gj] = CW'(coef_fixed(TAP_MILLI[gm][gj], COEF_FRAC_BITS));
    end
  end

  always_comb begin
    for (int j = 0; j < MAX_TAPS; j++) begin
      mul_a[j] = PW'($signed(op.hist[j]));
      mul_b[j] = PW'(coef_rom[op.mode][j]);
    end
  end

  always_comb begin
    for (int g = 0; g < NGRP; g++) begin
      grp_sum[g] = '0;
    end
    for (int j = 0; j < MAX_TAPS; j++) begin
      grp_sum[j / GRP] = grp_sum[j / GRP] + AW'(prod[j]);
    end
  end

  always_comb begin
    shifted = s3_total >>> COEF_FRAC_BITS;
    if (shifted > SAT_HI) begin
      sat_val = SAT_HI[SAMPLE_WIDTH-1:0];
    end else if (shifted < SAT_LO) begin
      sat_val = SAT_LO[SAMPLE_WIDTH-1:0];
    end else begin
      sat_val = shifted[SAMPLE_WIDTH-1:0];
    end
  end

  assign advance = !result_valid || result_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid      <= 1'b0;
      s1_valid     <= 1'b0;
      s2_valid     <= 1'b0;
      s3_valid     <= 1'b0;
      result_valid <= 1'b0;
    end else if (advance) begin
      p_valid      <= op_valid;
      s1_valid     <= p_valid;
      s2_valid     <= s1_valid;
      s3_valid     <= s2_valid;
      result_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      for (int j = 0; j < MAX_TAPS; j++) begin
        prod[j] <= mul_a[j] * mul_b[j];
      end
      p_smooth  <= op.smooth;
      p_last    <= op.last;
      p_raw     <= op.raw;

      s1_sum    <= grp_sum;
      s1_smooth <= p_smooth;
      s1_last   <= p_last;
      s1_raw    <= p_raw;

      s2_sum[0] <= s1_sum[0] + s1_sum[1];
      s2_sum[1] <= s1_sum[2] + s1_sum[3];
      s2_smooth <= s1_smooth;
      s2_last   <= s1_last;
      s2_raw    <= s1_raw;

      s3_total  <= s2_sum[0] + s2_sum[1] + ROUND;
      s3_smooth <= s2_smooth;
      s3_last   <= s2_last;
      s3_raw    <= s2_raw;

      result_word.sample_out <= s3_smooth ? sat_val : s3_raw;
      result_word.last_out   <= s3_last;
    end
  end

  a_issue_on_advance: assert property (@(posedge clk) disable iff (rst)
    op_valid |-> advance)
    else $error("op issued into stalled pipeline");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    !advance |=> $stable({p_valid, s1_valid, s2_valid, s3_valid}))
    else $error("pipeline moved while output stalled");

  a_out_from_s3: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(s3_valid))
    else $error("output word without a source stage");

endmodule

// ----- rtl/savitzky_golay_smoother_top.sv -----
// ----------------------------------------------------------------------------
// savitzky_golay_smoother_top
// Savitzky-Golay FIR smoother for framed signed sample streams.
//
//   channel   signals                                     payload
//   sample    sample_valid / sample_ready                 sample_word (sgs_in_t)
//   result    result_valid / result_ready                 result_word (sgs_out_t)
//   config    cfg_we / cfg_wdata                          window mode, 2 bits
//
// One sample accepted per cycle while the job queue is not full; each job is
// queued on acceptance and its words pass through the five-stage MAC pipe.
// A frame-end sample yields up to six words, issued one per cycle by the
// sequencer while the MAC pipe advances; the two-entry job queue then fills
// and sample_ready drops. A stalled result word holds the whole MAC pipe;
// the front keeps taking samples until the queue is full.
// Reset is synchronous; window mode resets to order 2, five left and right.
// ----------------------------------------------------------------------------
module savitzky_golay_smoother_top #(
  parameter int COEF_FRAC_BITS = sgs_pkg::COEF_FRAC_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              sample_valid,
  output logic              sample_ready,
  input  sgs_pkg::sgs_in_t  sample_word,
  output logic              result_valid,
  input  logic              result_ready,
  output sgs_pkg::sgs_out_t result_word,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_wdata
);
  import sgs_pkg::*;

  sgs_push_t push_req;
  sgs_job_t  head;
  sgs_op_t   op;
  logic      queue_full;
  logic      queue_empty;
  logic      pop;
  logic      advance;
  logic      op_valid;

  sgs_front u_front (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .sample_word  (sample_word),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .queue_full   (queue_full),
    .push_req     (push_req)
  );

  sgs_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push_req (push_req),
    .full     (queue_full),
    .pop      (pop),
    .empty    (queue_empty),
    .head     (head)
  );

  sgs_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .empty    (queue_empty),
    .head     (head),
    .pop      (pop),
    .advance  (advance),
    .op_valid (op_valid),
    .op       (op)
  );

  sgs_mac #(
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_mac (
    .clk          (clk),
    .rst          (rst),
    .op_valid     (op_valid),
    .op           (op),
    .advance      (advance),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result_word  (result_word)
  );

endmodule

// ----- verif/tb_savitzky_golay_smoother_top.sv -----
// ----------------------------------------------------------------------------
// tb_savitzky_golay_smoother_top
// Self-checking bench for the Savitzky-Golay smoother. An in-bench predictor
// keeps its own sample history and frame count, computes the expected output
// words for every accepted sample, and a result process compares each word
// taken from the block against the oldest prediction. Directed frames cover
// saturation and frame-edge pass-through; random frames of mixed length run
// under every window mode with random idling on both sides and a long
// result holdoff.
// ----------------------------------------------------------------------------
module tb_savitzky_golay_smoother_top;

  localparam int SW           = sgs_pkg::SAMPLE_WIDTH;
  localparam int FRAC         = sgs_pkg::COEF_FRAC_BITS_DEF;
  localparam int TAPS         = sgs_pkg::MAX_TAPS;
  localparam int SETTLE       = 16;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int HOLD_CYCLES  = 80;
  localparam longint SAT_HI   = (64'sd1 <<< (SW - 1)) - 1;
  localparam longint SAT_LO   = -(64'sd1 <<< (SW - 1));
  localparam sgs_pkg::sample_t SAMPLE_MAX = {1'b0, {(SW - 1){1'b1}}};
  localparam sgs_pkg::sample_t SAMPLE_MIN = {1'b1, {(SW - 1){1'b0}}};

  // weights in thousandths, oldest sample first
  localparam int WEIGHT_MILLI [4][TAPS] = '{
    '{ -86,  343, 486, 343,  -86,   0,   0,    0,   0,  0,   0},
    '{ 257,  372, 343, 171, -143,   0,   0,    0,   0,  0,   0},
    '{ -84,   21, 103, 161,  196, 206, 196,  161, 103, 21, -84},
    '{  35, -128,  70, 315,  416, 315,  70, -128,  35,  0,   0}
  };

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               sample_valid = 1'b0;
  logic               sample_ready;
  sgs_pkg::sgs_in_t   sample_word = '0;
  logic               result_valid;
  logic               result_ready = 1'b0;
  sgs_pkg::sgs_out_t  result_word;
  logic               cfg_we = 1'b0;
  logic [1:0]         cfg_wdata = 2'b00;

  sgs_pkg::mode_t     win_mode = sgs_pkg::MODE_L5R5;
  longint             hist_line [TAPS];
  int                 frame_count = 0;
  sgs_pkg::sgs_out_t  pending_words [$];

  int                 mismatches = 0;
  int                 cycle_count = 0;
  bit                 no_idle = 1'b0;
  int                 hold_request = 0;
  int                 hold_left = 0;

  savitzky_golay_smoother_top dut (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .sample_word  (sample_word),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result_word  (result_word),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    for (int i = 0; i < TAPS; i++) hist_line[i] = 0;
  end

  function automatic int lead_taps(input sgs_pkg::mode_t m);
    case (m)
      sgs_pkg::MODE_L2R2: return 2;
      sgs_pkg::MODE_L1R3: return 1;
      sgs_pkg::MODE_L4R4: return 4;
      default:            return 5;
    endcase
  endfunction

  function automatic int lag_taps(input sgs_pkg::mode_t m);
    case (m)
      sgs_pkg::MODE_L2R2: return 2;
      sgs_pkg::MODE_L1R3: return 3;
      sgs_pkg::MODE_L4R4: return 4;
      default:            return 5;
    endcase
  endfunction

  function automatic longint q15_weight(input int milli);
    longint mag;
    longint q;
    mag = (milli < 0) ? -longint'(milli) : longint'(milli);
    q = (mag * (64'sd1 <<< FRAC) + 500) / 1000;
    return (milli < 0) ? -q : q;
  endfunction

  function automatic sgs_pkg::sample_t smooth_window(input int taps);
    longint acc;
    acc = 0;
    for (int k = 0; k < taps; k++)
      acc += hist_line[taps - 1 - k] * q15_weight(WEIGHT_MILLI[int'(win_mode)][k]);
    acc = (acc + (64'sd1 <<< (FRAC - 1))) >>> FRAC;
    if (acc > SAT_HI) acc = SAT_HI;
    if (acc < SAT_LO) acc = SAT_LO;
    return sgs_pkg::sample_t'(acc);
  endfunction

  function automatic void predict_words(input sgs_pkg::sample_t s, input logic fin);
    int nl;
    int nr;
    int drain;
    sgs_pkg::sample_t v;
    nl = lead_taps(win_mode);
    nr = lag_taps(win_mode);
    for (int k = TAPS - 1; k > 0; k--) hist_line[k] = hist_line[k - 1];
    hist_line[0] = longint'(s);
    if (frame_count < TAPS) frame_count++;
    drain = (frame_count < nr) ? frame_count : nr;
    if (frame_count > nr) begin
      if (frame_count <= nl + nr) v = sgs_pkg::sample_t'(hist_line[nr]);
      else v = smooth_window(nl + nr + 1);
      pending_words.push_back('{sample_out: v, last_out: fin && (drain == 0)});
    end
    if (fin) begin
      for (int k = drain - 1; k >= 0; k--)
        pending_words.push_back('{sample_out: sgs_pkg::sample_t'(hist_line[k]),
                                  last_out: (k == 0)});
      frame_count = 0;
    end
  endfunction

  function automatic void check_word(input sgs_pkg::sgs_out_t got);
    sgs_pkg::sgs_out_t want;
    if (pending_words.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("unexpected word: sample_out=%0d last_out=%0b",
                 $signed(got.sample_out), got.last_out);
    end else begin
      want = pending_words.pop_front();
      if (want.sample_out !== got.sample_out || want.last_out !== got.last_out) begin
        mismatches++;
        if (mismatches <= 10)
          $display("word mismatch: sample_out exp %0d got %0d, last_out exp %0b got %0b",
                   $signed(want.sample_out), $signed(got.sample_out),
                   want.last_out, got.last_out);
      end
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      result_ready <= 1'b0;
    end else begin
      if (result_valid && result_ready) check_word(result_word);
      if (hold_request > 0) begin
        hold_left = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        result_ready <= 1'b0;
      end else begin
        result_ready <= no_idle || ($urandom_range(0, 99) >= 25);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("savitzky_golay_smoother_top test failed");
      $finish;
    end
  end

  task automatic send_sample(input sgs_pkg::sample_t s, input logic fin);
    int gap;
    if (!no_idle && $urandom_range(0, 99) < 25) begin
      sample_valid <= 1'b0;
      gap = $urandom_range(1, 3);
      repeat (gap) @(posedge clk);
    end
    sample_word <= '{sample_in: s, frame_end: fin};
    sample_valid <= 1'b1;
    @(posedge clk);
    while (!sample_ready) @(posedge clk);
    predict_words(s, fin);
  endtask

  task automatic wait_idle();
    sample_valid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_mode(input sgs_pkg::mode_t m);
    cfg_wdata <= m;
    cfg_we <= 1'b1;
    @(posedge clk);
    cfg_we <= 1'b0;
    win_mode = m;
  endtask

  function automatic sgs_pkg::sample_t pick_sample();
    case ($urandom_range(0, 7))
      0: return SAMPLE_MAX;
      1: return SAMPLE_MIN;
      2: return sgs_pkg::sample_t'($signed($urandom_range(0, 2000)) - 1000);
      3: return SAMPLE_MAX - sgs_pkg::sample_t'($urandom_range(0, 255));
      4: return SAMPLE_MIN + sgs_pkg::sample_t'($urandom_range(0, 255));
      default: return sgs_pkg::sample_t'($urandom);
    endcase
  endfunction

  task automatic test_reset_window();
    send_sample(SAMPLE_MAX, 1'b1);
    send_sample(SAMPLE_MIN, 1'b0);
    send_sample('0, 1'b1);
    wait_idle();
  endtask

  task automatic test_saturation();
    write_mode(sgs_pkg::MODE_L4R4);
    send_sample(SAMPLE_MAX, 1'b0);
    send_sample(SAMPLE_MIN, 1'b0);
    repeat (5) send_sample(SAMPLE_MAX, 1'b0);
    send_sample(SAMPLE_MIN, 1'b0);
    send_sample(SAMPLE_MAX, 1'b1);
    wait_idle();
    write_mode(sgs_pkg::MODE_L2R2);
    send_sample(SAMPLE_MAX, 1'b0);
    repeat (3) send_sample(SAMPLE_MIN, 1'b0);
    send_sample(SAMPLE_MAX, 1'b1);
    wait_idle();
  endtask

  task automatic test_drain_only();
    write_mode(sgs_pkg::MODE_L1R3);
    send_sample('0, 1'b0);
    send_sample(-24'sd1, 1'b0);
    send_sample(24'sd1, 1'b1);
    wait_idle();
  endtask

  task automatic test_result_holdoff();
    write_mode(sgs_pkg::MODE_L5R5);
    no_idle = 1'b1;
    hold_request = HOLD_CYCLES;
    for (int i = 0; i < 30; i++) send_sample(pick_sample(), i == 29);
    no_idle = 1'b0;
    wait_idle();
  endtask

  task automatic run_mode_phase(input sgs_pkg::mode_t m, input int items);
    int left;
    int len;
    write_mode(m);
    left = items;
    while (left > 0) begin
      len = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 12) : $urandom_range(13, 28);
      if (len > left) len = left;
      for (int i = 0; i < len; i++) send_sample(pick_sample(), i == len - 1);
      left -= len;
    end
    wait_idle();
  endtask

  task automatic test_random_streams();
    run_mode_phase(sgs_pkg::MODE_L2R2, 22);
    no_idle = 1'b1;
    run_mode_phase(sgs_pkg::MODE_L4R4, 22);
    no_idle = 1'b0;
    run_mode_phase(sgs_pkg::MODE_L1R3, 22);
    run_mode_phase(sgs_pkg::MODE_L5R5, 22);
    run_mode_phase(sgs_pkg::MODE_L4R4, 22);
    run_mode_phase(sgs_pkg::MODE_L2R2, 22);
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_window();
    test_saturation();
    test_drain_only();
    test_result_holdoff();
    test_random_streams();
    wait_idle();
    if (mismatches == 0)
      $display("savitzky_golay_smoother_top test passed");
    else
      $display("savitzky_golay_smoother_top test failed");
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/sgs_pkg.sv
rtl/sgs_front.sv
rtl/sgs_queue.sv
rtl/sgs_seq.sv
rtl/sgs_mac.sv
rtl/savitzky_golay_smoother_top.sv
verif/tb_savitzky_golay_smoother_top.sv
